FILE: src/sge_pkg.sv
// Shared types and constants for the stiffened-gas state evaluator.
// Beat layouts for the divider and square-root cell rows; no dependencies.
package sge_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int ONE        = 1 << FRAC_W;
   localparam int GAM_W      = 22;
   localparam int BP_W       = 31;
   localparam int EPS_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int DVD_W      = 64;
   localparam int DVS_W      = 31;
   localparam int DIV_STEPS  = DVD_W;
   localparam int SIDE_W     = 80;
   localparam int ROOT_W     = DATA_W - 1;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int INNER_W    = 58;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAT_RATIO     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STIFF_PRESSURE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENERGY_SHIFT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TINY_FLOOR     = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] mass;
      logic signed [DATA_W-1:0] mom_x;
      logic signed [DATA_W-1:0] mom_y;
      logic signed [DATA_W-1:0] mom_z;
      logic signed [DATA_W-1:0] total_energy;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pressure_out;
      logic signed [DATA_W-1:0] enthalpy_out;
      logic [ROOT_W-1:0]        sound_speed;
      logic                     pressure_clamped;
      logic                     saturated;
   } rsp_type;

   // One restoring-division step: quotient bits shift into the dividend's low end
   typedef struct packed {
      logic              valid;
      logic [DVD_W-1:0]  dvd;
      logic [DVS_W-1:0]  rem;
      logic [DVS_W-1:0]  dvs;
      logic [SIDE_W-1:0] side;
   } div_beat_type;

   // One digit-by-digit square-root step
   typedef struct packed {
      logic              valid;
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W+1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [SIDE_W-1:0] side;
   } root_beat_type;

   // Sideband carried along the kinetic-energy divider row
   typedef struct packed {
      logic signed [DATA_W-1:0] en;
      logic signed [47:0]       rho_a;
   } pre_side_type;

   // Sideband carried along the enthalpy divider row
   typedef struct packed {
      logic signed [DATA_W-1:0] p;
      logic                     neg;
      logic                     clamped;
      logic                     sat;
   } hq_side_type;

   // Sideband carried along the square-root row
   typedef struct packed {
      logic signed [DATA_W-1:0] p;
      logic signed [DATA_W-1:0] h;
      logic                     clamped;
      logic                     sat;
      logic                     big;
   } root_side_type;

endpackage

FILE: src/sge_div_cell.sv
// One cell of a restoring divider row: one quotient bit per cycle while advance is high.
// Depends on sge_pkg for the beat layout.
module sge_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  sge_pkg::div_beat_type beat_in,
   output sge_pkg::div_beat_type beat_out
);

   sge_pkg::div_beat_type beat_ff;
   sge_pkg::div_beat_type beat_in_step;
   logic [sge_pkg::DVS_W:0] trial;
   logic                    take;

   // Shift in one dividend bit, subtract the divisor when it fits
   always_comb begin
      trial = {beat_in.rem, beat_in.dvd[sge_pkg::DVD_W-1]};
      take  = trial >= {1'b0, beat_in.dvs};
      beat_in_step     = beat_in;
      beat_in_step.dvd = {beat_in.dvd[sge_pkg::DVD_W-2:0], take};
      beat_in_step.rem = take ? sge_pkg::DVS_W'(trial - {1'b0, beat_in.dvs})
                              : trial[sge_pkg::DVS_W-1:0];
   end

   // Advance with the row, clear valid on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in_step;
      end
   end

   assign beat_out = beat_ff;

endmodule

FILE: src/sge_root_cell.sv
// One cell of the integer square-root row: one root bit per cycle while advance is high.
// Depends on sge_pkg for the beat layout.
module sge_root_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  sge_pkg::root_beat_type beat_in,
   output sge_pkg::root_beat_type beat_out
);

   sge_pkg::root_beat_type beat_ff;
   sge_pkg::root_beat_type beat_in_step;
   logic [sge_pkg::ROOT_W+3:0] trial_rem;
   logic [sge_pkg::ROOT_W+3:0] trial;
   logic                       take;

   // Bring down two radicand bits, try root*4+1
   always_comb begin
      trial_rem = {beat_in.rem, beat_in.rad[sge_pkg::RAD_W-1 -: 2]};
      trial     = {2'b00, beat_in.root, 2'b01};
      take      = trial_rem >= trial;
      beat_in_step      = beat_in;
      beat_in_step.rad  = {beat_in.rad[sge_pkg::RAD_W-3:0], 2'b00};
      beat_in_step.root = {beat_in.root[sge_pkg::ROOT_W-2:0], take};
      beat_in_step.rem  = take ? (sge_pkg::ROOT_W+2)'(trial_rem - trial)
                               : trial_rem[sge_pkg::ROOT_W+1:0];
   end

   // Advance with the row, clear valid on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in_step;
      end
   end

   assign beat_out = beat_ff;

endmodule

FILE: src/stiffened_gas_state_evaluator_unit.sv
// Stiffened-gas state evaluator: pressure, enthalpy and sound speed per cell.
// Accepts one beat per cycle while a held result is not stalled.
// Each beat passes two 64-cell divider rows in series and a 31-cell root row.
// A stalled result freezes the whole pipeline. Synchronous reset clears the
// valid bits and loads the register defaults. Depends on sge_pkg and the cells.
module stiffened_gas_state_evaluator_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sge_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sge_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [sge_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sge_pkg::DATA_W-1:0]       csr_wdata
);

   localparam logic signed [65:0] INNER_CAP = 66'sd1 <<< 56;
   localparam logic signed [65:0] P_MAX     = 66'sd2147483647;
   localparam logic signed [65:0] P_MIN     = -66'sd2147483648;
   localparam logic [63:0]        H_POS_MAX = 64'd2147483647;
   localparam logic [63:0]        H_NEG_MAX = 64'd2147483648;
   localparam logic [63:0]        C2_BIG    = 64'd1 << 46;

   // Configuration registers
   logic [sge_pkg::GAM_W-1:0]        heat_ratio_ff;
   logic [sge_pkg::BP_W-1:0]         stiff_pressure_ff;
   logic signed [sge_pkg::DATA_W-1:0] energy_shift_ff;
   logic [sge_pkg::EPS_W-1:0]        tiny_floor_ff;
   logic [sge_pkg::EPS_W-1:0]        eps;

   logic adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         heat_ratio_ff     <= sge_pkg::GAM_W'(91750);
         stiff_pressure_ff <= '0;
         energy_shift_ff   <= '0;
         tiny_floor_ff     <= sge_pkg::EPS_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            sge_pkg::CSR_HEAT_RATIO:     heat_ratio_ff     <= csr_wdata[sge_pkg::GAM_W-1:0];
            sge_pkg::CSR_STIFF_PRESSURE: stiff_pressure_ff <= csr_wdata[sge_pkg::BP_W-1:0];
            sge_pkg::CSR_ENERGY_SHIFT:   energy_shift_ff   <= $signed(csr_wdata);
            sge_pkg::CSR_TINY_FLOOR:     tiny_floor_ff     <= csr_wdata[sge_pkg::EPS_W-1:0];
            default: ;
         endcase
      end
   end

   assign eps = (tiny_floor_ff == '0) ? sge_pkg::EPS_W'(1) : tiny_floor_ff;

   // Whole pipeline moves unless a finished result is held
   logic rsp_valid_ff;
   sge_pkg::rsp_type rsp_data_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // Stage 1: floor mass, square momenta, mass times energy shift
   logic [31:0] mag_x, mag_y, mag_z;
   logic [sge_pkg::DVS_W-1:0] s1_rho_f_in;
   logic        s1_valid_ff;
   logic [63:0] s1_sq_x_ff, s1_sq_y_ff, s1_sq_z_ff;
   logic signed [63:0] s1_rho_a_ff;
   logic [sge_pkg::DVS_W-1:0] s1_rho_f_ff;
   logic signed [sge_pkg::DATA_W-1:0] s1_en_ff;

   always_comb begin
      mag_x = req_data.mom_x[31] ? (~req_data.mom_x + 32'd1) : req_data.mom_x;
      mag_y = req_data.mom_y[31] ? (~req_data.mom_y + 32'd1) : req_data.mom_y;
      mag_z = req_data.mom_z[31] ? (~req_data.mom_z + 32'd1) : req_data.mom_z;
      s1_rho_f_in = (req_data.mass > $signed({15'd0, eps}))
                    ? req_data.mass[sge_pkg::DVS_W-1:0] : {14'd0, eps};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s1_sq_x_ff  <= mag_x * mag_x;
         s1_sq_y_ff  <= mag_y * mag_y;
         s1_sq_z_ff  <= mag_z * mag_z;
         s1_rho_a_ff <= req_data.mass * energy_shift_ff;
         s1_rho_f_ff <= s1_rho_f_in;
         s1_en_ff    <= req_data.total_energy;
      end
   end

   // Stage 2: sum squares, halve, launch into the kinetic divider row
   sge_pkg::div_beat_type kin_beat_in, kin_beat_ff;
   sge_pkg::pre_side_type pre_side;
   logic [63:0] ksum;

   always_comb begin
      ksum           = s1_sq_x_ff + s1_sq_y_ff + s1_sq_z_ff;
      pre_side.en    = s1_en_ff;
      pre_side.rho_a = $signed(s1_rho_a_ff[63:16]);
      kin_beat_in.valid = s1_valid_ff;
      kin_beat_in.dvd   = {1'b0, ksum[63:1]};
      kin_beat_in.rem   = '0;
      kin_beat_in.dvs   = s1_rho_f_ff;
      kin_beat_in.side  = pre_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kin_beat_ff.valid <= 1'b0;
      end else if (adv) begin
         kin_beat_ff <= kin_beat_in;
      end
   end

   sge_pkg::div_beat_type kin_chain [0:sge_pkg::DIV_STEPS];
   assign kin_chain[0] = kin_beat_ff;

   for (genvar i = 0; i < sge_pkg::DIV_STEPS; i++) begin : g_kin
      sge_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (adv),
         .beat_in  (kin_chain[i]),
         .beat_out (kin_chain[i+1])
      );
   end

   // Stage 3: internal energy term, held within the cap
   sge_pkg::pre_side_type kin_side;
   logic signed [65:0] inner_w;
   logic signed [sge_pkg::INNER_W-1:0] s3_inner_in;
   logic        s3_valid_ff;
   logic signed [sge_pkg::INNER_W-1:0] s3_inner_ff;
   logic [sge_pkg::DVS_W-1:0] s3_rho_f_ff;
   logic signed [sge_pkg::DATA_W-1:0] s3_en_ff;

   always_comb begin
      kin_side = kin_chain[sge_pkg::DIV_STEPS].side;
      inner_w  = 66'(kin_side.en) - $signed({2'd0, kin_chain[sge_pkg::DIV_STEPS].dvd})
                 - 66'(kin_side.rho_a);
      priority if (inner_w > INNER_CAP) begin
         s3_inner_in = INNER_CAP[sge_pkg::INNER_W-1:0];
      end else if (inner_w < -INNER_CAP) begin
         s3_inner_in = $signed(-INNER_CAP[sge_pkg::INNER_W-1:0]);
      end else begin
         s3_inner_in = inner_w[sge_pkg::INNER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= kin_chain[sge_pkg::DIV_STEPS].valid;
         s3_inner_ff <= s3_inner_in;
         s3_rho_f_ff <= kin_chain[sge_pkg::DIV_STEPS].dvs;
         s3_en_ff    <= kin_side.en;
      end
   end

   // Stage 4: (gamma - 1) times inner in two halves, gamma times B
   logic signed [22:0] gm1;
   logic [52:0] gb_full;
   logic        s4_valid_ff;
   logic signed [64:0] s4_prod_hi_ff;
   logic signed [39:0] s4_lo_prod_ff;
   logic [36:0] s4_gb_ff;
   logic [sge_pkg::DVS_W-1:0] s4_rho_f_ff;
   logic signed [sge_pkg::DATA_W-1:0] s4_en_ff;

   always_comb begin
      gm1     = $signed({1'b0, heat_ratio_ff}) - $signed(23'(sge_pkg::ONE));
      gb_full = heat_ratio_ff * stiff_pressure_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff   <= s3_valid_ff;
         s4_prod_hi_ff <= gm1 * $signed(s3_inner_ff[sge_pkg::INNER_W-1:16]);
         s4_lo_prod_ff <= gm1 * $signed({1'b0, s3_inner_ff[15:0]});
         s4_gb_ff      <= gb_full[52:16];
         s4_rho_f_ff   <= s3_rho_f_ff;
         s4_en_ff      <= s3_en_ff;
      end
   end

   // Stage 5: raw pressure
   logic        s5_valid_ff;
   logic signed [65:0] s5_p_ff;
   logic [sge_pkg::DVS_W-1:0] s5_rho_f_ff;
   logic signed [sge_pkg::DATA_W-1:0] s5_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= s4_valid_ff;
         s5_p_ff     <= 66'(s4_prod_hi_ff) + 66'($signed(s4_lo_prod_ff[39:16]))
                        - $signed({29'd0, s4_gb_ff});
         s5_rho_f_ff <= s4_rho_f_ff;
         s5_en_ff    <= s4_en_ff;
      end
   end

   // Stage 6: clamp at eps - B, saturate to the data range
   logic signed [32:0] p_floor;
   logic signed [65:0] p_cl;
   logic        clamp_in;
   logic signed [sge_pkg::DATA_W-1:0] s6_p_in;
   logic        sat6_in;
   logic        s6_valid_ff;
   logic signed [sge_pkg::DATA_W-1:0] s6_p_ff;
   logic        s6_clamped_ff;
   logic        s6_sat_ff;
   logic [sge_pkg::DVS_W-1:0] s6_rho_f_ff;
   logic signed [sge_pkg::DATA_W-1:0] s6_en_ff;

   always_comb begin
      p_floor  = $signed({16'd0, eps}) - $signed({2'd0, stiff_pressure_ff});
      clamp_in = s5_p_ff < 66'(p_floor);
      p_cl     = clamp_in ? 66'(p_floor) : s5_p_ff;
      sat6_in  = 1'b0;
      priority if (p_cl > P_MAX) begin
         s6_p_in = P_MAX[sge_pkg::DATA_W-1:0];
         sat6_in = 1'b1;
      end else if (p_cl < P_MIN) begin
         s6_p_in = P_MIN[sge_pkg::DATA_W-1:0];
         sat6_in = 1'b1;
      end else begin
         s6_p_in = p_cl[sge_pkg::DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff   <= s5_valid_ff;
         s6_p_ff       <= s6_p_in;
         s6_clamped_ff <= clamp_in;
         s6_sat_ff     <= sat6_in;
         s6_rho_f_ff   <= s5_rho_f_ff;
         s6_en_ff      <= s5_en_ff;
      end
   end

   // Stage 7: enthalpy and squared-sound-speed numerators into two divider rows
   logic [32:0] sum_u, mag_h, pb_w;
   logic [53:0] c2_num;
   sge_pkg::hq_side_type hq_side;
   sge_pkg::div_beat_type h_beat_in, h_beat_ff, c_beat_in, c_beat_ff;

   always_comb begin
      sum_u  = 33'(s6_p_ff) + 33'(s6_en_ff);
      mag_h  = sum_u[32] ? (~sum_u + 33'd1) : sum_u;
      pb_w   = 33'(s6_p_ff) + $signed({2'd0, stiff_pressure_ff});
      c2_num = heat_ratio_ff * pb_w[31:0];
      hq_side.p       = s6_p_ff;
      hq_side.neg     = sum_u[32];
      hq_side.clamped = s6_clamped_ff;
      hq_side.sat     = s6_sat_ff;
      h_beat_in.valid = s6_valid_ff;
      h_beat_in.dvd   = 64'({mag_h, 16'd0});
      h_beat_in.rem   = '0;
      h_beat_in.dvs   = s6_rho_f_ff;
      h_beat_in.side  = sge_pkg::SIDE_W'(hq_side);
      c_beat_in.valid = s6_valid_ff;
      c_beat_in.dvd   = 64'(c2_num);
      c_beat_in.rem   = '0;
      c_beat_in.dvs   = s6_rho_f_ff;
      c_beat_in.side  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_beat_ff.valid <= 1'b0;
         c_beat_ff.valid <= 1'b0;
      end else if (adv) begin
         h_beat_ff <= h_beat_in;
         c_beat_ff <= c_beat_in;
      end
   end

   sge_pkg::div_beat_type h_chain [0:sge_pkg::DIV_STEPS];
   sge_pkg::div_beat_type c_chain [0:sge_pkg::DIV_STEPS];
   assign h_chain[0] = h_beat_ff;
   assign c_chain[0] = c_beat_ff;

   for (genvar i = 0; i < sge_pkg::DIV_STEPS; i++) begin : g_quo
      sge_div_cell u_h_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (adv),
         .beat_in  (h_chain[i]),
         .beat_out (h_chain[i+1])
      );
      sge_div_cell u_c_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (adv),
         .beat_in  (c_chain[i]),
         .beat_out (c_chain[i+1])
      );
   end

   // Stage 8: sign and saturate enthalpy, floor c^2, launch the root row
   sge_pkg::hq_side_type   hq_out;
   sge_pkg::root_side_type rt_side;
   logic [63:0] hq, c2q, c2f;
   logic signed [sge_pkg::DATA_W-1:0] h_val;
   logic        h_sat;
   logic        big;
   sge_pkg::root_beat_type root_beat_in, root_beat_ff;

   always_comb begin
      hq_out = sge_pkg::hq_side_type'(
         h_chain[sge_pkg::DIV_STEPS].side[$bits(sge_pkg::hq_side_type)-1:0]);
      hq     = h_chain[sge_pkg::DIV_STEPS].dvd;
      c2q    = c_chain[sge_pkg::DIV_STEPS].dvd;
      h_sat  = 1'b0;
      priority if (!hq_out.neg && hq > H_POS_MAX) begin
         h_val = H_POS_MAX[sge_pkg::DATA_W-1:0];
         h_sat = 1'b1;
      end else if (hq_out.neg && hq > H_NEG_MAX) begin
         h_val = H_NEG_MAX[sge_pkg::DATA_W-1:0];
         h_sat = 1'b1;
      end else if (hq_out.neg) begin
         h_val = $signed(~hq[sge_pkg::DATA_W-1:0] + 32'd1);
      end else begin
         h_val = $signed(hq[sge_pkg::DATA_W-1:0]);
      end
      c2f = (c2q < {47'd0, eps}) ? {47'd0, eps} : c2q;
      big = c2f >= C2_BIG;
      rt_side.p       = hq_out.p;
      rt_side.h       = h_val;
      rt_side.clamped = hq_out.clamped;
      rt_side.sat     = hq_out.sat | h_sat | big;
      rt_side.big     = big;
      root_beat_in.valid = h_chain[sge_pkg::DIV_STEPS].valid;
      root_beat_in.rad   = {c2f[45:0], 16'd0};
      root_beat_in.rem   = '0;
      root_beat_in.root  = '0;
      root_beat_in.side  = sge_pkg::SIDE_W'(rt_side);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_beat_ff.valid <= 1'b0;
      end else if (adv) begin
         root_beat_ff <= root_beat_in;
      end
   end

   sge_pkg::root_beat_type root_chain [0:sge_pkg::ROOT_STEPS];
   assign root_chain[0] = root_beat_ff;

   for (genvar i = 0; i < sge_pkg::ROOT_STEPS; i++) begin : g_root
      sge_root_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (adv),
         .beat_in  (root_chain[i]),
         .beat_out (root_chain[i+1])
      );
   end

   // Output register: assemble the result beat, hold it while stalled
   sge_pkg::root_side_type out_side;
   sge_pkg::rsp_type       rsp_data_in;

   always_comb begin
      out_side = sge_pkg::root_side_type'(
         root_chain[sge_pkg::ROOT_STEPS].side[$bits(sge_pkg::root_side_type)-1:0]);
      rsp_data_in.pressure_out     = out_side.p;
      rsp_data_in.enthalpy_out     = out_side.h;
      rsp_data_in.sound_speed      = out_side.big ? {sge_pkg::ROOT_W{1'b1}}
                                                  : root_chain[sge_pkg::ROOT_STEPS].root;
      rsp_data_in.pressure_clamped = out_side.clamped;
      rsp_data_in.saturated        = out_side.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= root_chain[sge_pkg::ROOT_STEPS].valid;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_last_cell_reaches_output: assert property (@(posedge clock) disable iff (reset)
      adv && root_chain[sge_pkg::ROOT_STEPS].valid |=> rsp_valid_ff)
      else $error("finished beat did not reach the output register");

   a_clamp_stays_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.pressure_clamped |->
         rsp_data_ff.pressure_out <= 32'sd131071)
      else $error("clamped pressure above the largest floor");

   a_sound_speed_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.sound_speed >= 31'd256)
      else $error("sound speed below root of the smallest floor");
`endif

endmodule

FILE: tb/sv/sge_checker.sv
// Checker for the stiffened-gas state evaluator: watches both channels and the CSR port,
// predicts each result from the register copy and compares beat by beat.
// Depends on sge_pkg.
module sge_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  sge_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  sge_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [sge_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sge_pkg::DATA_W-1:0]    csr_wdata,
   output int                            fail_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint INNER_LIM = longint'(1) << 56;
   localparam longint S32_HI    = 64'sd2147483647;
   localparam longint S32_LO    = -64'sd2147483648;

   logic [sge_pkg::GAM_W-1:0]         gam_q;
   logic [sge_pkg::BP_W-1:0]          bp_q;
   logic signed [sge_pkg::DATA_W-1:0] shift_q;
   logic [sge_pkg::EPS_W-1:0]         eps_q;

   sge_pkg::rsp_type cell_results[$];

   function automatic longint floor_shift(longint x);
      return x >>> sge_pkg::FRAC_W;
   endfunction

   function automatic longint clip32(longint v, ref bit sat);
      if (v > S32_HI) begin
         sat = 1;
         return S32_HI;
      end
      if (v < S32_LO) begin
         sat = 1;
         return S32_LO;
      end
      return v;
   endfunction

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic sge_pkg::rsp_type eval_cell(sge_pkg::req_type c);
      sge_pkg::rsp_type r;
      bit sat, clamped;
      longint rho, en, eps, bp, gam, rho_f, kin, rho_a, inner, gm1, hi, lo, prod, gb, p, h;
      longint unsigned ax, ay, az, ksum, pb, c2, cs;
      sat = 0;
      clamped = 0;
      rho = longint'(c.mass);
      en = longint'(c.total_energy);
      eps = (eps_q == 0) ? 1 : longint'(eps_q);
      bp = longint'(bp_q);
      gam = longint'(gam_q);
      rho_f = (rho > eps) ? rho : eps;
      ax = c.mom_x < 0 ? longint'(-longint'(c.mom_x)) : longint'(c.mom_x);
      ay = c.mom_y < 0 ? longint'(-longint'(c.mom_y)) : longint'(c.mom_y);
      az = c.mom_z < 0 ? longint'(-longint'(c.mom_z)) : longint'(c.mom_z);
      ksum = ax * ax + ay * ay + az * az;
      kin = longint'(ksum / (64'd2 * longint'(rho_f)));
      rho_a = floor_shift(rho * longint'(shift_q));
      inner = en - kin - rho_a;
      if (inner > INNER_LIM) inner = INNER_LIM;
      if (inner < -INNER_LIM) inner = -INNER_LIM;
      gm1 = gam - sge_pkg::ONE;
      hi = floor_shift(inner);
      lo = inner & (sge_pkg::ONE - 1);
      prod = gm1 * hi + floor_shift(gm1 * lo);
      gb = longint'((longint'(gam) * longint'(bp)) >> sge_pkg::FRAC_W);
      p = prod - gb;
      if (p < eps - bp) begin
         p = eps - bp;
         clamped = 1;
      end
      p = clip32(p, sat);
      h = clip32(((en + p) * sge_pkg::ONE) / rho_f, sat);
      pb = p + bp;
      c2 = (longint'(gam) * pb) / longint'(rho_f);
      if (c2 < eps) c2 = eps;
      if (c2 >= (64'd1 << (62 - sge_pkg::FRAC_W))) begin
         cs = 64'h7fffffff;
         sat = 1;
      end else begin
         cs = int_root(c2 << sge_pkg::FRAC_W);
         if (cs > 64'h7fffffff) begin
            cs = 64'h7fffffff;
            sat = 1;
         end
      end
      r.pressure_out = p[31:0];
      r.enthalpy_out = h[31:0];
      r.sound_speed = cs[30:0];
      r.pressure_clamped = clamped;
      r.saturated = sat;
      return r;
   endfunction

   assign pending_count = cell_results.size();

   // Track registers, queue predictions, compare results
   always @(posedge clock) begin
      sge_pkg::rsp_type want;
      if (reset) begin
         gam_q <= sge_pkg::GAM_W'(91750);
         bp_q <= '0;
         shift_q <= '0;
         eps_q <= sge_pkg::EPS_W'(1);
         cell_results.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) cell_results.push_back(eval_cell(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (cell_results.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = cell_results.pop_front();
               if (want.pressure_out !== rsp_data.pressure_out ||
                   want.enthalpy_out !== rsp_data.enthalpy_out ||
                   want.sound_speed !== rsp_data.sound_speed ||
                   want.pressure_clamped !== rsp_data.pressure_clamped ||
                   want.saturated !== rsp_data.saturated) begin
                  $display("%0t: mismatch expected p=%h h=%h c=%h cl=%b s=%b", $time,
                           want.pressure_out, want.enthalpy_out, want.sound_speed,
                           want.pressure_clamped, want.saturated);
                  $display("%0t:          actual   p=%h h=%h c=%h cl=%b s=%b", $time,
                           rsp_data.pressure_out, rsp_data.enthalpy_out,
                           rsp_data.sound_speed, rsp_data.pressure_clamped,
                           rsp_data.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               sge_pkg::CSR_HEAT_RATIO: gam_q <= csr_wdata[sge_pkg::GAM_W-1:0];
               sge_pkg::CSR_STIFF_PRESSURE: bp_q <= csr_wdata[sge_pkg::BP_W-1:0];
               sge_pkg::CSR_ENERGY_SHIFT: shift_q <= csr_wdata;
               sge_pkg::CSR_TINY_FLOOR: eps_q <= csr_wdata[sge_pkg::EPS_W-1:0];
               default: ;
            endcase
         end
      end
   end
endmodule

FILE: tb/sv/tb_stiffened_gas_state_evaluator_unit.sv
// Top of the stiffened-gas evaluator testbench: clock, reset, CSR phases and cell stimulus.
// Depends on sge_pkg, the unit and sge_checker.
module tb_stiffened_gas_state_evaluator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_DEPTH = 168;
   localparam int CYCLE_LIMIT = 400000;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   sge_pkg::req_type req_data;
   sge_pkg::rsp_type rsp_data;
   logic csr_we;
   logic [sge_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sge_pkg::DATA_W-1:0] csr_wdata;
   int fail_count, pending_count;
   int cycle_count;
   bit calm_mode;   // no random idling when set
   bit hold_off;    // long receiver hold-off

   stiffened_gas_state_evaluator_unit u_top (.*);
   sge_checker u_chk (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver stall
   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else rsp_stall <= hold_off || (!calm_mode && $urandom_range(99) < 9);
   end

   // Send one cell beat, idling at random beforehand; valid stays up afterwards
   task automatic send_cell(sge_pkg::req_type c);
      while (!calm_mode && $urandom_range(99) < 9) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [sge_pkg::CSR_IDX_W-1:0] idx,
                            logic [sge_pkg::DATA_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   // Drop valid, then wait until every beat has come out
   task automatic drain;
      req_valid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 10) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(65536 * 8);
         3: return -$urandom_range(65536 * 8);
         default: return $urandom();
      endcase
   endfunction

   function automatic sge_pkg::req_type rand_cell();
      sge_pkg::req_type c;
      c.mass = ($urandom_range(3) == 0) ? rand_field() : $urandom_range(1 << 20);
      c.mom_x = ($urandom_range(1)) ? rand_field() : $urandom_range(1 << 18) - (1 << 17);
      c.mom_y = ($urandom_range(1)) ? rand_field() : $urandom_range(1 << 18) - (1 << 17);
      c.mom_z = ($urandom_range(1)) ? rand_field() : $urandom_range(1 << 18) - (1 << 17);
      c.total_energy = ($urandom_range(1)) ? rand_field() : $urandom_range(1 << 24);
      return c;
   endfunction

   task automatic directed_cells;
      sge_pkg::req_type c;
      c = '{32'h00010000, 0, 0, 0, 32'h00020000};
      send_cell(c);
      c = '{0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0};
      send_cell(c);
      c = '{32'h80000000, 1, -1, 0, 32'h80000000};
      send_cell(c);
      c = '{32'h7fffffff, 0, 0, 0, 32'h7fffffff};
      send_cell(c);
      c = '{32'h00000001, 32'h00010000, 0, 0, 32'h80000000};
      send_cell(c);
      c = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
      send_cell(c);
      c = '{32'h00008000, 32'h00004000, 32'h00002000, 32'h00001000, 32'h7fff0000};
      send_cell(c);
   endtask

   initial begin
      sge_pkg::req_type c;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      cycle_count = 0;
      calm_mode = 0;
      hold_off = 0;
      repeat (5) @(negedge clock);
      reset = 0;

      // Defaults, then a high and a low setting of every register
      directed_cells();
      drain();
      write_reg(sge_pkg::CSR_HEAT_RATIO, 32'd2097152);
      write_reg(sge_pkg::CSR_STIFF_PRESSURE, 32'h7fffffff);
      write_reg(sge_pkg::CSR_ENERGY_SHIFT, 32'h80000000);
      write_reg(sge_pkg::CSR_TINY_FLOOR, 32'd65536);
      directed_cells();
      drain();
      write_reg(sge_pkg::CSR_HEAT_RATIO, 32'd0);
      write_reg(sge_pkg::CSR_STIFF_PRESSURE, 32'd0);
      write_reg(sge_pkg::CSR_ENERGY_SHIFT, 32'h7fffffff);
      write_reg(sge_pkg::CSR_TINY_FLOOR, 32'd0);
      directed_cells();
      drain();

      // Random phases with fresh register settings
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(sge_pkg::CSR_HEAT_RATIO,
                   (ph == 4) ? $urandom() : $urandom_range(2097152, 65536));
         write_reg(sge_pkg::CSR_STIFF_PRESSURE,
                   (ph == 4) ? $urandom() : $urandom_range(1 << 22));
         write_reg(sge_pkg::CSR_ENERGY_SHIFT,
                   (ph < 2) ? $urandom_range(1 << 17) - (1 << 16) : $urandom());
         write_reg(sge_pkg::CSR_TINY_FLOOR,
                   (ph == 4) ? $urandom() : $urandom_range(65536, 1));
         calm_mode = (ph == 2);
         fork
            begin
               if (ph == 1) begin
                  hold_off = 1;
                  repeat (400) @(negedge clock);
                  hold_off = 0;
               end
            end
            for (int n = 0; n < 80; n++) begin
               c = rand_cell();
               send_cell(c);
            end
         join
         drain();
      end

      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

FILE: filelist.f
src/sge_pkg.sv
src/sge_div_cell.sv
src/sge_root_cell.sv
src/stiffened_gas_state_evaluator_unit.sv
tb/sv/sge_checker.sv
tb/sv/tb_stiffened_gas_state_evaluator_unit.sv
